// ===== sv/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants for the learned route cache
// Entry layout, scan result, result codes and register indexes.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int ROUTE_ENTRIES_DEF = 8;
    localparam int SLOT_W            = 6;

    localparam logic [15:0] NET_RSVD_LO = 16'h0000;
    localparam logic [15:0] NET_RSVD_HI = 16'hffff;

    // result codes
    localparam logic [2:0] STAT_IGNORED  = 3'd0;
    localparam logic [2:0] STAT_HIT      = 3'd1;
    localparam logic [2:0] STAT_MISS     = 3'd2;
    localparam logic [2:0] STAT_SAME     = 3'd3;
    localparam logic [2:0] STAT_CHANGED  = 3'd4;
    localparam logic [2:0] STAT_NEW      = 3'd5;
    localparam logic [2:0] STAT_REPLACED = 3'd6;

    // register indexes
    localparam logic CFG_DEFAULT_IP   = 1'b0;
    localparam logic CFG_DEFAULT_PORT = 1'b1;

    localparam logic MODE_LEARN  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [15:0] net;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] seen;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       net;
        logic [31:0]       ip;
        logic [15:0]       port;
        logic [31:0]       seen;
    } tbl_wr_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] hit_slot;
        logic [31:0]       hit_ip;
        logic [15:0]       hit_port;
        logic              empty_found;
        logic [SLOT_W-1:0] empty_slot;
        logic [SLOT_W-1:0] old_slot;
    } scan_res_t;

endpackage

// ===== sv/lrc_table.sv =====
// ----------------------------------------------------------------------------
// lrc_table: route entry storage
// Valid marks in flops cleared by reset; entry fields in a memory with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module lrc_table #(
    parameter int ROUTE_ENTRIES = lrc_pkg::ROUTE_ENTRIES_DEF,
    parameter int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output lrc_pkg::entry_t    rd_entry,
    input  lrc_pkg::tbl_wr_t   wr
);

    logic               valid_reg [ROUTE_ENTRIES];
    logic [15:0]        net_mem   [ROUTE_ENTRIES];
    logic [31:0]        ip_mem    [ROUTE_ENTRIES];
    logic [15:0]        port_mem  [ROUTE_ENTRIES];
    logic [31:0]        seen_mem  [ROUTE_ENTRIES];
    lrc_pkg::entry_t    rd_entry_reg;
    logic [IDX_W-1:0]   wr_addr;

    assign wr_addr  = wr.slot[IDX_W-1:0];
    assign rd_entry = rd_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROUTE_ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (wr.en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            net_mem[wr_addr]  <= wr.net;
            ip_mem[wr_addr]   <= wr.ip;
            port_mem[wr_addr] <= wr.port;
            seen_mem[wr_addr] <= wr.seen;
        end
        if (rd_en)
        begin
            rd_entry_reg.valid <= valid_reg[rd_addr];
            rd_entry_reg.net   <= net_mem[rd_addr];
            rd_entry_reg.ip    <= ip_mem[rd_addr];
            rd_entry_reg.port  <= port_mem[rd_addr];
            rd_entry_reg.seen  <= seen_mem[rd_addr];
        end
    end

endmodule

// ===== sv/lrc_scan.sv =====
// ----------------------------------------------------------------------------
// lrc_scan: per-entry compare unit
// Takes one entry per cycle; tracks first match, first empty slot and the
// entry with the smallest timestamp.
// ----------------------------------------------------------------------------
module lrc_scan (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         eval,
    input  logic [lrc_pkg::SLOT_W-1:0]   slot,
    input  lrc_pkg::entry_t              entry,
    input  logic [15:0]                  key_net,
    output lrc_pkg::scan_res_t           res
);

    lrc_pkg::scan_res_t res_reg, res_next;
    logic [31:0]        old_seen_reg, old_seen_next;
    logic               match;

    assign match = entry.valid && (entry.net == key_net);
    assign res   = res_reg;

    always_comb
    begin
        res_next      = res_reg;
        old_seen_next = old_seen_reg;
        if (clear)
        begin
            res_next.found       = 1'b0;
            res_next.empty_found = 1'b0;
        end
        else if (eval)
        begin
            if (match && !res_reg.found)
            begin
                res_next.found    = 1'b1;
                res_next.hit_slot = slot;
                res_next.hit_ip   = entry.ip;
                res_next.hit_port = entry.port;
            end
            if (!entry.valid && !res_reg.empty_found)
            begin
                res_next.empty_found = 1'b1;
                res_next.empty_slot  = slot;
            end
            // strict less-than keeps the first of equal timestamps
            if ((slot == '0) || (entry.seen < old_seen_reg))
            begin
                res_next.old_slot = slot;
                old_seen_next     = entry.seen;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg      <= '0;
            old_seen_reg <= '0;
        end
        else
        begin
            res_reg      <= res_next;
            old_seen_reg <= old_seen_next;
        end
    end

endmodule

// ===== sv/learned_route_cache.sv =====
// ----------------------------------------------------------------------------
// learned_route_cache: network number to peer address cache
// From request accept to result valid the sequencer scans every entry
// (one entry compared per cycle through the registered table read port);
// reserved networks skip the scan and go straight to the finish state.
// A new request is not taken until the current one finishes (req_stall is
// high outside idle); a result held by rsp_stall holds the finish.
// Reset: async active low; valid marks, counters and config clear at once.
// ----------------------------------------------------------------------------
module learned_route_cache #(
    parameter int ROUTE_ENTRIES = lrc_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        mode,
    input  logic [15:0] net_number,
    input  logic [31:0] peer_ip,
    input  logic [15:0] peer_udp_port,
    input  logic [31:0] now_ms,
    // result channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [31:0] target_ip,
    output logic [15:0] target_port,
    output logic [5:0]  slot_index,
    output logic [31:0] learned_total,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total
);

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]  state_reg, state_next;

    // latched request
    logic        mode_reg;
    logic [15:0] net_reg;
    logic [31:0] ip_reg;
    logic [15:0] port_reg;
    logic [31:0] now_reg;
    logic        rsvd_reg;

    // scan pointers: issue side feeds the table, check side the compare unit
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             issue_reg, issue_next;
    logic [IDX_W-1:0] chk_reg, chk_next;
    logic             pend_reg, pend_next;

    logic [31:0] dflt_ip_reg;
    logic [15:0] dflt_port_reg;
    logic [31:0] learn_cnt_reg, learn_cnt_next;
    logic [31:0] hit_cnt_reg, hit_cnt_next;
    logic [31:0] miss_cnt_reg, miss_cnt_next;

    // result register
    logic        rsp_valid_reg, rsp_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] tip_reg, tip_next;
    logic [15:0] tport_reg, tport_next;
    logic [5:0]  slot_reg, slot_next;

    logic               req_fire;
    logic               out_load;
    logic               scan_clear;
    logic               scan_eval;
    lrc_pkg::entry_t    rd_entry;
    lrc_pkg::tbl_wr_t   tbl_wr;
    lrc_pkg::scan_res_t scan_res;
    logic               net_rsvd;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign net_rsvd  = (net_number == lrc_pkg::NET_RSVD_LO)
                    || (net_number == lrc_pkg::NET_RSVD_HI);

    // result register can take a new value once the old one is gone
    assign out_load   = (state_reg == ST_FINISH) && (!rsp_valid_reg || !rsp_stall);
    assign scan_clear = req_fire;
    assign scan_eval  = (state_reg == ST_SCAN) && pend_reg;

    lrc_table #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    ((state_reg == ST_SCAN) && issue_reg),
        .rd_addr  (scan_reg),
        .rd_entry (rd_entry),
        .wr       (tbl_wr)
    );

    lrc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (scan_clear),
        .eval    (scan_eval),
        .slot    (lrc_pkg::SLOT_W'(chk_reg)),
        .entry   (rd_entry),
        .key_net (net_reg),
        .res     (scan_res)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        issue_next = issue_reg;
        chk_next   = chk_reg;
        pend_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    scan_next  = '0;
                    issue_next = 1'b1;
                    state_next = net_rsvd ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                pend_next = issue_reg;
                chk_next  = scan_reg;
                if (issue_reg)
                begin
                    if (scan_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
                if (pend_reg && (chk_reg == LAST_IDX))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // decision, table write and counters, all on the finishing cycle
    always_comb
    begin
        status_next    = status_reg;
        tip_next       = tip_reg;
        tport_next     = tport_reg;
        slot_next      = slot_reg;
        learn_cnt_next = learn_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        tbl_wr.en      = 1'b0;
        tbl_wr.slot    = scan_res.hit_slot;
        tbl_wr.net     = net_reg;
        tbl_wr.ip      = ip_reg;
        tbl_wr.port    = port_reg;
        tbl_wr.seen    = now_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
            status_next    = lrc_pkg::STAT_IGNORED;
            tip_next       = dflt_ip_reg;
            tport_next     = dflt_port_reg;
            slot_next      = '0;
            if (rsvd_reg)
            begin
                // reserved network: nothing changes
            end
            else if (mode_reg == lrc_pkg::MODE_LOOKUP)
            begin
                if (scan_res.found)
                begin
                    status_next  = lrc_pkg::STAT_HIT;
                    tip_next     = scan_res.hit_ip;
                    tport_next   = scan_res.hit_port;
                    slot_next    = scan_res.hit_slot;
                    hit_cnt_next = hit_cnt_reg + 32'd1;
                end
                else
                begin
                    status_next   = lrc_pkg::STAT_MISS;
                    miss_cnt_next = miss_cnt_reg + 32'd1;
                end
            end
            else
            begin
                tbl_wr.en  = 1'b1;
                tip_next   = ip_reg;
                tport_next = port_reg;
                if (scan_res.found)
                begin
                    status_next = ((scan_res.hit_ip != ip_reg)
                                || (scan_res.hit_port != port_reg))
                                ? lrc_pkg::STAT_CHANGED : lrc_pkg::STAT_SAME;
                end
                else
                begin
                    learn_cnt_next = learn_cnt_reg + 32'd1;
                    if (scan_res.empty_found)
                    begin
                        status_next = lrc_pkg::STAT_NEW;
                        tbl_wr.slot = scan_res.empty_slot;
                    end
                    else
                    begin
                        status_next = lrc_pkg::STAT_REPLACED;
                        tbl_wr.slot = scan_res.old_slot;
                    end
                end
                slot_next = tbl_wr.slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            learn_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            dflt_ip_reg   <= '0;
            dflt_port_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            learn_cnt_reg <= learn_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lrc_pkg::CFG_DEFAULT_IP:   dflt_ip_reg   <= cfg_data;
                    lrc_pkg::CFG_DEFAULT_PORT: dflt_port_reg <= cfg_data[15:0];
                    default:                   dflt_ip_reg   <= dflt_ip_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        chk_reg    <= chk_next;
        status_reg <= status_next;
        tip_reg    <= tip_next;
        tport_reg  <= tport_next;
        slot_reg   <= slot_next;
        if (req_fire)
        begin
            mode_reg <= mode;
            net_reg  <= net_number;
            ip_reg   <= peer_ip;
            port_reg <= peer_udp_port;
            now_reg  <= now_ms;
            rsvd_reg <= net_rsvd;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign target_ip     = tip_reg;
    assign target_port   = tport_reg;
    assign slot_index    = slot_reg;
    assign learned_total = learn_cnt_reg;
    assign hit_total     = hit_cnt_reg;
    assign miss_total    = miss_cnt_reg;

    // an accepted request always starts work
    a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // the table is only written when a learn request finishes
    a_wr_only_learn: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.en |-> (out_load && !rsvd_reg && (mode_reg == lrc_pkg::MODE_LEARN)))
        else $error("table write outside a learn finish");

    // finishing a request always presents a result
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> rsp_valid_reg)
        else $error("finished request produced no result");

    // the compare unit only sees entries during a scan
    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_eval |-> (state_reg == ST_SCAN) && !req_fire)
        else $error("compare unit active outside scan");

endmodule
